### rtl/core/cfpe_pkg.sv
// Package for the symbolic Cholesky row-pattern engine.
// Holds the request structs, controller state, command/status groups and constants.
// No dependencies; cfpe_ctrl, cfpe_dp, the top level and the testbench import it.
package cfpe_pkg;

    localparam int W_FIELD = 6;
    localparam int PAR_W = 7;
    localparam logic [PAR_W-1:0] NO_PARENT = 7'd127;

    typedef struct packed {
        logic [W_FIELD-1:0] row;
        logic [W_FIELD-1:0] col;
        logic               row_end;
    } t_in_req;

    typedef struct packed {
        logic [W_FIELD-1:0] out_row;
        logic [W_FIELD-1:0] out_col;
        logic               last;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_WB,
        ST_EMIT,
        ST_EMIT_DIAG
    } t_state;

    typedef struct packed {
        logic accept;
        logic walk_rd;
        logic walk_wb;
        logic emit_step;
        logic emit_diag;
    } t_cmd;

    typedef struct packed {
        logic in_ok;
        logic in_walk;
        logic in_end;
        logic row_end;
        logic node_marked;
        logic walk_stop;
        logic scan_adv;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

### rtl/core/cfpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cfpe_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cfpe_ctrl.sv
// Controller state machine of the row-pattern engine.
// Depends on cfpe_pkg; drives commands to cfpe_dp and reads its status.
module cfpe_ctrl
    import cfpe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.in_ok) begin
                    if (i_status.in_walk) begin
                        n_state = ST_WALK_RD;
                    end else if (i_status.in_end) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_WALK_RD: begin
                if (i_status.node_marked) begin
                    n_state = i_status.row_end ? ST_EMIT : ST_IDLE;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = ST_WALK_WB;
                end
            end
            ST_WALK_WB: begin
                o_cmd.walk_wb = 1'b1;
                if (i_status.walk_stop) begin
                    n_state = i_status.row_end ? ST_EMIT : ST_IDLE;
                end else begin
                    n_state = ST_WALK_RD;
                end
            end
            ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_status.scan_adv && i_status.scan_last) begin
                    n_state = ST_EMIT_DIAG;
                end
            end
            ST_EMIT_DIAG: begin
                if (i_status.out_free) begin
                    o_cmd.emit_diag = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/cfpe_dp.sv
// Datapath of the row-pattern engine: row marks, walk pointer, parent RAM, output register.
// Depends on cfpe_pkg and cfpe_ram; steered by commands from cfpe_ctrl.
module cfpe_dp
    import cfpe_pkg::*;
#(
    parameter int MAX_ORDER = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_req  i_in_req,
    input  t_cmd     i_cmd,
    output t_status  o_status,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam logic [PAR_W-1:0] MAX_P = PAR_W'(MAX_ORDER);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDER - 1);

    logic [MAX_ORDER-1:0] r_marks;
    logic [MAX_ORDER-1:0] n_marks;
    logic                 r_row_open;
    logic [W_FIELD-1:0]   r_cur_row;
    logic                 r_end;
    logic [IDX_W-1:0]     r_node;
    logic [IDX_W-1:0]     r_scan;
    logic                 r_out_valid;
    t_out_req             r_out_req;

    logic [IDX_W-1:0]     in_row_idx;
    logic [IDX_W-1:0]     cur_idx;
    logic                 opening;
    logic [PAR_W-1:0]     rdata;
    logic [PAR_W-1:0]     next_node;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [PAR_W-1:0]     ram_wdata;
    logic                 scan_need;
    logic                 scan_adv;
    logic                 out_free;
    logic                 load_scan;

    assign in_row_idx = i_in_req.row[IDX_W-1:0];
    assign cur_idx = r_cur_row[IDX_W-1:0];
    assign opening = !r_row_open || (i_in_req.row != r_cur_row);

    assign next_node = (rdata == NO_PARENT) ? {1'b0, r_cur_row} : rdata;

    assign out_free = !r_out_valid || !i_out_stall;
    assign scan_need = r_marks[r_scan] && (r_scan != cur_idx);
    assign scan_adv = !scan_need || out_free;
    assign load_scan = i_cmd.emit_step && scan_need && out_free;

    always_comb begin
        o_status = '0;
        o_status.in_ok = {1'b0, i_in_req.row} < MAX_P;
        o_status.in_walk = i_in_req.col < i_in_req.row;
        o_status.in_end = i_in_req.row_end;
        o_status.row_end = r_end;
        o_status.node_marked = r_marks[r_node];
        o_status.walk_stop = next_node >= MAX_P;
        o_status.scan_adv = scan_adv;
        o_status.scan_last = r_scan == LAST_IDX;
        o_status.out_free = out_free;
    end

    // Parent writes: a new row gets no parent, a rootless node on the walk gets the row.
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = in_row_idx;
        ram_wdata = NO_PARENT;
        if (i_cmd.accept && o_status.in_ok && opening) begin
            ram_we = 1'b1;
        end else if (i_cmd.walk_wb && (rdata == NO_PARENT)) begin
            ram_we = 1'b1;
            ram_waddr = r_node;
            ram_wdata = {1'b0, r_cur_row};
        end
    end

    cfpe_ram #(
        .WIDTH (PAR_W),
        .DEPTH (MAX_ORDER)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.walk_rd),
        .i_raddr (r_node),
        .o_rdata (rdata)
    );

    always_comb begin
        n_marks = r_marks;
        if (i_cmd.accept && o_status.in_ok && opening) begin
            n_marks = '0;
            n_marks[in_row_idx] = 1'b1;
        end else if (i_cmd.walk_wb) begin
            n_marks[r_node] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_row_open <= 1'b0;
            r_cur_row <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_marks <= n_marks;
            if (i_cmd.accept && o_status.in_ok) begin
                r_row_open <= 1'b1;
                r_cur_row <= i_in_req.row;
            end else if (i_cmd.emit_diag) begin
                r_row_open <= 1'b0;
            end
            if (load_scan || i_cmd.emit_diag) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_end <= i_in_req.row_end;
            r_node <= i_in_req.col[IDX_W-1:0];
            r_scan <= '0;
        end else begin
            if (i_cmd.walk_wb) begin
                r_node <= next_node[IDX_W-1:0];
            end
            if (i_cmd.emit_step && scan_adv) begin
                r_scan <= r_scan + IDX_W'(1);
            end
        end
        if (load_scan) begin
            r_out_req.out_row <= r_cur_row;
            r_out_req.out_col <= W_FIELD'(r_scan);
            r_out_req.last <= 1'b0;
        end else if (i_cmd.emit_diag) begin
            r_out_req.out_row <= r_cur_row;
            r_out_req.out_col <= r_cur_row;
            r_out_req.last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req = r_out_req;

endmodule

### rtl/core/cholesky_fill_pattern_etree.sv
// Symbolic Cholesky row-pattern engine: an accepted request is taken in ST_IDLE, then the
// elimination-tree walk handles each unmarked node with a parent RAM read, then an update,
// and stops on an already-marked node or on a parent link at or above MAX_ORDER.
// A row-end request adds a scan over all MAX_ORDER columns and then the diagonal result;
// output stalls hold the scan. One request is in work at a time.
// Reset is synchronous and active low: it clears controller state, row marks, the open-row
// flag and output valid; the parent RAM is not cleared but set per row as the row opens.
module cholesky_fill_pattern_etree
    import cfpe_pkg::*;
#(
    parameter int MAX_ORDER = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    // The controller sequences each request: accept, walk the tree from the entry's
    // column until a node already marked in this row is met, and on the row's last
    // request scan the mark bitmap in ascending column order before the diagonal.
    t_cmd    cmd;
    t_status status;

    cfpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the row marks in flip-flops, so that the walk can test a
    // node without a memory read, and the parent links in a RAM.
    cfpe_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    // A stalled result keeps its valid and its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("stalled result dropped or changed");

    // The diagonal result always names its own row.
    a_diag_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.last) |-> (o_out_req.out_col == o_out_req.out_row))
        else $error("diagonal result with a column other than its row");

    // An off-diagonal result never repeats the diagonal column.
    a_offdiag_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_req.last) |-> (o_out_req.out_col != o_out_req.out_row))
        else $error("off-diagonal result on the diagonal column");

endmodule

### tb/tb_cholesky_fill_pattern_etree.sv
// Self-checking testbench for the symbolic Cholesky row-pattern engine.
// Needs cfpe_pkg and cholesky_fill_pattern_etree; a small scoreboard class predicts every row.
`timescale 1ns / 100ps

class row_pattern_scoreboard;
    localparam int ORDER = 64;

    // Predictor state: elimination tree links, visited marks of the open row.
    logic [6:0]                parent [ORDER];
    logic [ORDER-1:0]          marks;
    logic [5:0]                open_row_idx;
    bit                        row_open;
    cfpe_pkg::t_out_req        pattern_q[$];
    int unsigned               errors;
    int unsigned               checked;
    int unsigned               requests;
    int unsigned               rows_closed;

    function new();
        foreach (parent[i]) parent[i] = '0;
        marks        = '0;
        open_row_idx = '0;
        row_open     = 1'b0;
        errors       = 0;
        checked      = 0;
        requests     = 0;
        rows_closed  = 0;
    endfunction

    function int unsigned pending();
        return pattern_q.size();
    endfunction

    // Appends one predicted result at the tail of the queue.
    function void add_expected(cfpe_pkg::t_out_req item);
        pattern_q.insert(pattern_q.size(), item);
    endfunction

    // Updates the tree for one accepted request and queues the row pattern on row_end.
    function void note_request(cfpe_pkg::t_in_req req);
        int unsigned        node;
        int unsigned        steps;
        cfpe_pkg::t_out_req item;
        requests++;
        if (!row_open || req.row != open_row_idx) begin
            marks             = '0;
            parent[req.row]   = cfpe_pkg::NO_PARENT;
            marks[req.row]    = 1'b1;
            open_row_idx      = req.row;
            row_open          = 1'b1;
        end
        if (req.col < req.row) begin
            node  = req.col;
            steps = 0;
            while (steps < ORDER && node < ORDER && !marks[node]) begin
                if (parent[node] == cfpe_pkg::NO_PARENT)
                    parent[node] = {1'b0, req.row};
                marks[node] = 1'b1;
                node        = parent[node];
                steps++;
            end
        end
        if (req.row_end) begin
            for (int j = 0; j < ORDER; j++) begin
                if (j != req.row && marks[j]) begin
                    item.out_row = req.row;
                    item.out_col = 6'(j);
                    item.last    = 1'b0;
                    add_expected(item);
                end
            end
            item.out_row = req.row;
            item.out_col = req.row;
            item.last    = 1'b1;
            add_expected(item);
            row_open = 1'b0;
            rows_closed++;
        end
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("MISMATCH: %s", what);
    endtask

    task check_result(cfpe_pkg::t_out_req got);
        cfpe_pkg::t_out_req want;
        if (pattern_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result row %0d col %0d last %0b",
                                      got.out_row, got.out_col, got.last));
            return;
        end
        want = pattern_q.pop_front();
        checked++;
        if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d, expected %0d (col %0d)",
                                      got.out_row, want.out_row, want.out_col));
        if (got.out_col !== want.out_col)
            report_mismatch($sformatf("out_col %0d, expected %0d (row %0d)",
                                      got.out_col, want.out_col, want.out_row));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b (row %0d col %0d)",
                                      got.last, want.last, want.out_row, want.out_col));
    endtask
endclass

module tb_cholesky_fill_pattern_etree
    import cfpe_pkg::*;
();

    localparam int          ORDER         = 64;
    // The limit leaves ample margin over the slowest plausible run.
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    // One request can walk 64 nodes, then scan 64 columns plus the
    // diagonal; this is how long we keep watching for stray output after the last result.
    localparam int unsigned SETTLE_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS   = 117;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_req  in_req    = '0;
    logic     out_stall = 1'b0;
    logic     in_stall;
    logic     out_valid;
    t_out_req out_req;

    // Idle and stall probabilities in percent, changed only between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;

    // Rows that have been opened since reset. A walk may only start at such a column,
    // because the parent link of any other node has never been written.
    logic [ORDER-1:0] row_seen = '0;

    row_pattern_scoreboard sb = new();

    cholesky_fill_pattern_etree #(
        .MAX_ORDER (ORDER)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Monitor: every handshake is sampled at the rising edge, before any nonblocking update
    // of that edge lands. Results are checked before the request of the same edge is noted,
    // since a request can never produce output at the edge where it is accepted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(out_req);
            if (in_valid && !in_stall)
                sb.note_request(in_req);
        end
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // Presents one request and holds it until the block takes it. An idle gap, when one
    // is drawn, drops valid for whole cycles; otherwise valid stays high back to back.
    task automatic send_req(input logic [5:0] r, input logic [5:0] c, input logic e);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_req.row     <= r;
        in_req.col     <= c;
        in_req.row_end <= e;
        row_seen[r]     = 1'b1;
        items_sent++;
        do @(posedge clk); while (in_stall);
    endtask

    // Mostly a column below the row whose link is known; otherwise one on or above the
    // diagonal, which the block must ignore as an entry.
    function automatic logic [5:0] pick_col(input logic [5:0] r);
        logic [5:0] c;
        if (r != 0 && $urandom_range(99) < 80) begin
            for (int t = 0; t < 16; t++) begin
                c = 6'($urandom_range(r - 1));
                if (row_seen[c])
                    return c;
            end
        end
        c = 6'($urandom_range(63, r));
        return c;
    endfunction

    // One row of the pattern; the last request carries row_end unless the row is dropped.
    task automatic send_row(input logic [5:0] r, input int unsigned n_items, input bit close);
        for (int unsigned k = 0; k < n_items; k++)
            send_req(r, pick_col(r), close && (k == n_items - 1));
    endtask

    // A well-formed matrix in row order, with a little noise: now and then a row is left
    // open and dropped, or an earlier row is sent again out of order. No new row starts
    // once the phase's request budget is used up.
    task automatic send_matrix(input int unsigned n, input int unsigned stop_at);
        logic [5:0] back;
        for (int unsigned r = 0; r < n && items_sent < stop_at; r++) begin
            send_row(6'(r), $urandom_range(3, 1), $urandom_range(99) >= 6);
            if ($urandom_range(99) < 5) begin
                do back = 6'($urandom_range(63)); while (!row_seen[back]);
                send_row(back, $urandom_range(2, 1), 1'b1);
            end
        end
    endtask

    // The sender holds off until every predicted result has come out. The first cycle
    // is always spent so that the last accepted request is already noted.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_start;
        int unsigned n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a diagonal-only row, simple chains, an entry above the diagonal,
        // a dropped row, a row revisited out of order, col equal to row with row_end,
        // a jump to the last row, and row zero with the largest column.
        send_req(6'd0,  6'd0,  1'b1);
        send_req(6'd1,  6'd0,  1'b1);
        send_req(6'd2,  6'd63, 1'b0);
        send_req(6'd2,  6'd1,  1'b1);
        send_req(6'd3,  6'd0,  1'b0);
        send_req(6'd3,  6'd2,  1'b1);
        send_req(6'd4,  6'd3,  1'b0);
        send_req(6'd5,  6'd4,  1'b0);
        send_req(6'd5,  6'd1,  1'b1);
        send_req(6'd2,  6'd0,  1'b1);
        send_req(6'd5,  6'd5,  1'b1);
        send_req(6'd63, 6'd3,  1'b0);
        send_req(6'd63, 6'd5,  1'b1);
        send_req(6'd0,  6'd63, 1'b1);
        send_req(6'd1,  6'd1,  1'b0);
        send_req(6'd1,  6'd0,  1'b1);
        wait_drain();

        // Random part in four traffic settings. Most matrices are small; about one in
        // eight is large enough to reach the top rows and long tree paths.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(64, 33) : $urandom_range(12, 2);
                send_matrix(n, phase_start + PHASE_ITEMS);
                // Occasionally let the block run completely dry between matrices.
                if ($urandom_range(3) == 0)
                    wait_drain();
            end
            wait_drain();
        end

        // Keep watching for stray output once nothing more is expected.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Run covered %0d requests and %0d closed rows; %0d pattern entries checked.",
                 sb.requests, sb.rows_closed, sb.checked);
        $display("Traffic went through no idling, sender gaps, receiver stalls and both.");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/cfpe_pkg.sv
rtl/core/cfpe_ram.sv
rtl/core/cfpe_ctrl.sv
rtl/core/cfpe_dp.sv
rtl/core/cholesky_fill_pattern_etree.sv
tb/tb_cholesky_fill_pattern_etree.sv
